FILE: rtl/core/tleg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tleg_pkg;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_W   = 25;
    localparam int LEVEL_W = 26;

    typedef logic [REG_W-1:0]          t_reg;
    typedef logic signed [LEVEL_W-1:0] t_level;

    localparam t_level LVL_ZERO = '0;

    typedef enum logic [2:0] {
        ST_ATTACK  = 3'd0,
        ST_DECAY   = 3'd1,
        ST_SUSTAIN = 3'd2,
        ST_RELEASE = 3'd3,
        ST_DONE    = 3'd4
    } t_stage;

    // register indexes, byte address = 4 * index
    localparam logic [2:0] REG_INITIAL_LEVEL = 3'd0;
    localparam logic [2:0] REG_ATTACK_LEVEL  = 3'd1;
    localparam logic [2:0] REG_ATTACK_STEP   = 3'd2;
    localparam logic [2:0] REG_DECAY_STEP    = 3'd3;
    localparam logic [2:0] REG_RELEASE_STEP  = 3'd4;

    localparam t_reg RST_INITIAL_LEVEL = 25'h0800000;
    localparam t_reg RST_ATTACK_LEVEL  = 25'h1000000;
    localparam t_reg RST_ATTACK_STEP   = 25'd16777;
    localparam t_reg RST_DECAY_STEP    = 25'd16777;
    localparam t_reg RST_RELEASE_STEP  = 25'd16777;

    typedef struct packed {
        t_reg initial_level;
        t_reg attack_level;
        t_reg attack_step;
        t_reg decay_step;
        t_reg release_step;
    } t_cfg;

    typedef struct packed {
        t_level level;
        t_stage stage;
        logic   pending;
    } t_state;

    typedef struct packed {
        logic key_on;
        logic key_retrigger;
        logic key_off;
    } t_keys;

endpackage

`default_nettype wire

FILE: rtl/core/tleg_key_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tleg_key_if;
    logic valid;
    logic ready;
    logic key_on;
    logic key_retrigger;
    logic key_off;

    modport source (output valid, output key_on, output key_retrigger, output key_off,
                    input ready);
    modport sink   (input valid, input key_on, input key_retrigger, input key_off,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tleg_env_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tleg_env_if;
    logic              valid;
    logic              ready;
    tleg_pkg::t_level  level;
    tleg_pkg::t_stage  stage;

    modport source (output valid, output level, output stage, input ready);
    modport sink   (input valid, input level, input stage, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tleg_apb_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module tleg_apb_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tleg_pkg::PADDR_W-1:0] paddr,
    input  logic [tleg_pkg::PDATA_W-1:0] pwdata,
    output logic [tleg_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output tleg_pkg::t_cfg               o_cfg
);
    import tleg_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] idx;
    t_reg       wdata;
    t_reg       rdata;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[4:2];
    assign wdata  = pwdata[REG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_level <= RST_INITIAL_LEVEL;
            r_cfg.attack_level  <= RST_ATTACK_LEVEL;
            r_cfg.attack_step   <= RST_ATTACK_STEP;
            r_cfg.decay_step    <= RST_DECAY_STEP;
            r_cfg.release_step  <= RST_RELEASE_STEP;
        end else if (wr_en) begin
            unique case (idx)
                REG_INITIAL_LEVEL: r_cfg.initial_level <= wdata;
                REG_ATTACK_LEVEL:  r_cfg.attack_level  <= wdata;
                REG_ATTACK_STEP:   r_cfg.attack_step   <= wdata;
                REG_DECAY_STEP:    r_cfg.decay_step    <= wdata;
                REG_RELEASE_STEP:  r_cfg.release_step  <= wdata;
                default: ;  // drop writes past the register list
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_INITIAL_LEVEL: rdata = r_cfg.initial_level;
            REG_ATTACK_LEVEL:  rdata = r_cfg.attack_level;
            REG_ATTACK_STEP:   rdata = r_cfg.attack_step;
            REG_DECAY_STEP:    rdata = r_cfg.decay_step;
            REG_RELEASE_STEP:  rdata = r_cfg.release_step;
            default:           rdata = '0;
        endcase
    end

    assign prdata = {{(PDATA_W-REG_W){1'b0}}, rdata};
    assign o_cfg  = r_cfg;

endmodule

`default_nettype wire

FILE: rtl/core/tleg_step.sv
`timescale 1ns / 1ps
`default_nettype none

module tleg_step (
    input  tleg_pkg::t_cfg   i_cfg,
    input  tleg_pkg::t_state i_state,
    input  tleg_pkg::t_keys  i_keys,
    output tleg_pkg::t_state o_state,
    output tleg_pkg::t_level o_level
);
    import tleg_pkg::*;

    t_level il;
    t_level al;
    t_level as_s;
    t_level ds_s;
    t_level rs_s;

    t_level l;
    t_stage s;
    logic   p;

    t_level add_a;
    t_level sub_a;
    t_level add_d;
    t_level sub_d;
    t_level sub_r;

    // decay outcome, also used when attack starts on its target
    t_level d_level;
    t_stage d_stage;
    t_level d_emit;

    t_level nl;
    t_stage ns;
    logic   np;
    t_level emit;

    assign il   = t_level'({1'b0, i_cfg.initial_level});
    assign al   = t_level'({1'b0, i_cfg.attack_level});
    assign as_s = t_level'({1'b0, i_cfg.attack_step});
    assign ds_s = t_level'({1'b0, i_cfg.decay_step});
    assign rs_s = t_level'({1'b0, i_cfg.release_step});

    // key handling: off, pending check, then retrigger / on
    always_comb begin
        l = i_state.level;
        s = i_state.stage;
        p = i_state.pending;
        if (i_keys.key_off) begin
            p = 1'b1;
            s = ST_RELEASE;
        end
        if (p && s != ST_ATTACK) begin
            s = ST_RELEASE;
        end
        if (i_keys.key_retrigger) begin
            s = ST_ATTACK;
        end else if (i_keys.key_on) begin
            s = ST_ATTACK;
            l = il;
        end
    end

    assign add_a = l + as_s;
    assign sub_a = l - as_s;
    assign add_d = l + ds_s;
    assign sub_d = l - ds_s;
    assign sub_r = l - rs_s;

    always_comb begin
        if (l < il) begin
            d_level = add_d;
            d_emit  = add_d;
            d_stage = (add_d >= il) ? ST_SUSTAIN : ST_DECAY;
        end else if (l > il) begin
            d_level = sub_d;
            d_emit  = sub_d;
            d_stage = (sub_d <= il) ? ST_SUSTAIN : ST_DECAY;
        end else begin
            // on target: pass through to sustain
            d_level = il;
            d_emit  = il;
            d_stage = ST_SUSTAIN;
        end
    end

    always_comb begin
        nl   = l;
        ns   = s;
        np   = p;
        emit = LVL_ZERO;
        unique case (s)
            ST_RELEASE: begin
                if (l > LVL_ZERO) begin
                    emit = sub_r;
                    if (sub_r <= LVL_ZERO) begin
                        nl = LVL_ZERO;
                        ns = ST_DONE;
                        np = 1'b0;
                    end else begin
                        nl = sub_r;
                    end
                end else begin
                    nl = LVL_ZERO;
                    ns = ST_DONE;
                    np = 1'b0;
                end
            end
            ST_ATTACK: begin
                if (l < al) begin
                    nl   = add_a;
                    emit = add_a;
                    ns   = (add_a >= al) ? ST_DECAY : ST_ATTACK;
                end else if (l > al) begin
                    nl   = sub_a;
                    emit = sub_a;
                    ns   = (sub_a <= al) ? ST_DECAY : ST_ATTACK;
                end else begin
                    nl   = d_level;
                    emit = d_emit;
                    ns   = d_stage;
                end
            end
            ST_DECAY: begin
                nl   = d_level;
                emit = d_emit;
                ns   = d_stage;
            end
            ST_SUSTAIN: begin
                nl   = il;
                emit = il;
            end
            default: begin
                ns   = ST_DONE;
                emit = LVL_ZERO;
            end
        endcase
    end

    assign o_state.level   = nl;
    assign o_state.stage   = ns;
    assign o_state.pending = np;
    assign o_level         = emit;

endmodule

`default_nettype wire

FILE: rtl/core/two_level_envelope_generator.sv
`timescale 1ns / 1ps
`default_nettype none

// Envelope generator, one sample per tick. Each key item (key_on, key_retrigger,
// key_off) yields exactly one result item carrying the envelope level (signed,
// 24 fractional bits, overshoot not clamped) and the stage after the tick
// (0 attack, 1 decay, 2 sustain, 3 release, 4 done). Rate: one item per clock
// sustained while o_env.ready holds; an accepted item goes from the input register
// to the result register, and the level/stage state is updated with it by the
// combinational step logic between those two registers. The result register
// decouples the two sides, so a new item is taken while a result waits, as long
// as the input register frees up in the same cycle. Registers sit on an APB port
// at byte addresses 0x00 initial_level, 0x04 attack_level, 0x08 attack_step,
// 0x0C decay_step, 0x10 release_step (25 bits each); write them only while idle.
// After reset the state is level 0, stage done, nothing pending; no clearing pass.

module two_level_envelope_generator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tleg_pkg::PADDR_W-1:0] paddr,
    input  logic [tleg_pkg::PDATA_W-1:0] pwdata,
    output logic [tleg_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    tleg_key_if.sink                     i_key,
    tleg_env_if.source                   o_env
);
    import tleg_pkg::*;

    t_cfg   cfg;

    // input register
    logic   r_in_valid;
    t_keys  r_in_keys;

    // envelope state
    t_state r_state;
    t_state n_state;
    t_level n_level;

    // result register
    logic   r_out_valid;
    t_level r_out_level;
    t_stage r_out_stage;

    logic   advance;
    t_keys  in_keys;

    tleg_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tleg_step u_step (
        .i_cfg   (cfg),
        .i_state (r_state),
        .i_keys  (r_in_keys),
        .o_state (n_state),
        .o_level (n_level)
    );

    // Move the held item into the result register when that slot is free
    // or being emptied this cycle; the state updates with it.
    assign advance     = r_in_valid && (!r_out_valid || o_env.ready);
    assign i_key.ready = !r_in_valid || advance;

    assign in_keys.key_on        = i_key.key_on;
    assign in_keys.key_retrigger = i_key.key_retrigger;
    assign in_keys.key_off       = i_key.key_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_state.level   <= LVL_ZERO;
            r_state.stage   <= ST_DONE;
            r_state.pending <= 1'b0;
        end else begin
            if (i_key.ready) begin
                r_in_valid <= i_key.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_env.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_key.valid && i_key.ready) begin
            r_in_keys <= in_keys;
        end
        if (advance) begin
            r_out_level <= n_level;
            r_out_stage <= n_state.stage;
        end
    end

    assign o_env.valid = r_out_valid;
    assign o_env.level = r_out_level;
    assign o_env.stage = r_out_stage;

`ifndef SYNTH
    // done is only reached through reset or release, which both clear level and pending
    a_done_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.stage == ST_DONE |-> (r_state.level == LVL_ZERO && !r_state.pending))
        else $error("done stage with nonzero level or pending release");

    // state moves only with an item
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("envelope state changed without an item");

    // a done result is the last release sample or zero, never positive
    a_done_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_stage == ST_DONE) |-> r_out_level <= LVL_ZERO)
        else $error("positive level reported with done stage");

    // a waiting result must not be overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_env.ready) |-> !advance)
        else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import tleg_pkg::*;

    localparam int          IDLE_PCT    = 19;
    localparam t_reg        FULL_SCALE  = 25'h1000000;
    localparam int unsigned SETTLE_CYC  = 4;
    localparam int unsigned RAND_PHASES = 10;
    localparam int unsigned PHASE_ITEMS = 100;

    typedef struct packed {
        t_level level;
        t_stage stage;
    } t_sample;

    logic i_clk;
    logic i_rst_n;

    // APB side
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    tleg_key_if key_bus ();
    tleg_env_if env_bus ();

    two_level_envelope_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_key   (key_bus),
        .o_env   (env_bus)
    );

    // Envelope shadow: register copy plus level, stage and pending release.
    t_cfg   cfg;
    longint env_level;
    t_stage env_stage;
    bit     release_armed;

    t_keys       pending_keys[$];
    t_sample     expected_samples[$];
    bit          key_fired;
    bit          steady;          // suppress idling on both sides
    int unsigned mismatch_count;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Wrap to the 26-bit two's complement level width.
    function automatic longint wrap_level(input longint v);
        t_level w;
        w = v[LEVEL_W-1:0];
        return w;
    endfunction

    // Advance the envelope by one tick and return the sample it emits.
    function automatic t_sample envelope_tick(input t_keys k);
        t_sample out;
        bit      emitted;
        longint  goal;
        longint  stride;
        t_stage  after;
        out.level = LVL_ZERO;
        emitted   = 1'b0;

        // key_off first, then the pending check, then retrigger / key_on
        if (k.key_off) begin
            release_armed = 1'b1;
            env_stage     = ST_RELEASE;
        end
        if (release_armed && env_stage != ST_ATTACK)
            env_stage = ST_RELEASE;
        if (k.key_retrigger) begin
            env_stage = ST_ATTACK;
        end else if (k.key_on) begin
            env_stage = ST_ATTACK;
            env_level = cfg.initial_level;
        end

        // stages already at their target fall through without a sample
        while (!emitted) begin
            case (env_stage)
                ST_RELEASE: begin
                    if (env_level > 0) begin
                        stride    = cfg.release_step;
                        env_level = wrap_level(env_level - stride);
                        out.level = env_level;
                        emitted   = 1'b1;
                    end
                    if (env_level <= 0) begin
                        env_level     = 0;
                        env_stage     = ST_DONE;
                        release_armed = 1'b0;
                    end
                end
                ST_ATTACK, ST_DECAY: begin
                    if (env_stage == ST_ATTACK) begin
                        goal   = cfg.attack_level;
                        stride = cfg.attack_step;
                        after  = ST_DECAY;
                    end else begin
                        goal   = cfg.initial_level;
                        stride = cfg.decay_step;
                        after  = ST_SUSTAIN;
                    end
                    if (env_level < goal) begin
                        env_level = wrap_level(env_level + stride);
                        out.level = env_level;
                        emitted   = 1'b1;
                        if (env_level >= goal)
                            env_stage = after;
                    end else if (env_level > goal) begin
                        env_level = wrap_level(env_level - stride);
                        out.level = env_level;
                        emitted   = 1'b1;
                        if (env_level <= goal)
                            env_stage = after;
                    end else begin
                        env_stage = after;
                    end
                end
                ST_SUSTAIN: begin
                    env_level = cfg.initial_level;
                    out.level = env_level;
                    emitted   = 1'b1;
                end
                default: begin
                    env_stage = ST_DONE;
                    out.level = LVL_ZERO;
                    emitted   = 1'b1;
                end
            endcase
        end
        out.stage = env_stage;
        return out;
    endfunction

    // Drive key items and sink stalls on the falling edge.
    always @(negedge i_clk) begin
        t_keys next_keys;
        if (!i_rst_n) begin
            key_bus.valid <= 1'b0;
            env_bus.ready <= 1'b0;
        end else begin
            if (!key_bus.valid || key_fired) begin
                if (pending_keys.size() > 0 &&
                    (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    next_keys             = pending_keys.pop_front();
                    key_bus.valid         <= 1'b1;
                    key_bus.key_on        <= next_keys.key_on;
                    key_bus.key_retrigger <= next_keys.key_retrigger;
                    key_bus.key_off       <= next_keys.key_off;
                end else begin
                    key_bus.valid <= 1'b0;
                end
            end
            env_bus.ready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    // Predict on each accepted key item, check each accepted sample.
    always @(posedge i_clk) begin
        t_keys   taken;
        t_sample want;
        if (!i_rst_n) begin
            key_fired <= 1'b0;
        end else begin
            key_fired <= key_bus.valid && key_bus.ready;
            if (key_bus.valid && key_bus.ready) begin
                taken.key_on        = key_bus.key_on;
                taken.key_retrigger = key_bus.key_retrigger;
                taken.key_off       = key_bus.key_off;
                expected_samples.push_back(envelope_tick(taken));
            end
            if (env_bus.valid && env_bus.ready) begin
                if (expected_samples.size() == 0) begin
                    $error("unexpected sample: level %0d stage %0d",
                           env_bus.level, env_bus.stage);
                    mismatch_count++;
                end else begin
                    want = expected_samples.pop_front();
                    if (env_bus.level !== want.level) begin
                        $error("level: expected %0d, got %0d", want.level, env_bus.level);
                        mismatch_count++;
                    end
                    if (env_bus.stage !== want.stage) begin
                        $error("stage: expected %0d, got %0d", want.stage, env_bus.stage);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    task automatic add_keys(input bit on, input bit retrig, input bit off,
                            input int unsigned times);
        t_keys k;
        k.key_on        = on;
        k.key_retrigger = retrig;
        k.key_off       = off;
        repeat (times) pending_keys.push_back(k);
    endtask

    // APB write; the register lands at the edge where the access phase meets pready.
    task automatic write_reg(input logic [2:0] index, input t_reg value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_INITIAL_LEVEL: cfg.initial_level = value;
            REG_ATTACK_LEVEL:  cfg.attack_level  = value;
            REG_ATTACK_STEP:   cfg.attack_step   = value;
            REG_DECAY_STEP:    cfg.decay_step    = value;
            REG_RELEASE_STEP:  cfg.release_step  = value;
            default: ;
        endcase
    endtask

    task automatic write_all(input t_reg init_lvl, input t_reg atk_lvl, input t_reg atk_step,
                             input t_reg dec_step, input t_reg rel_step);
        write_reg(REG_INITIAL_LEVEL, init_lvl);
        write_reg(REG_ATTACK_LEVEL,  atk_lvl);
        write_reg(REG_ATTACK_STEP,   atk_step);
        write_reg(REG_DECAY_STEP,    dec_step);
        write_reg(REG_RELEASE_STEP,  rel_step);
        @(posedge i_clk);
    endtask

    // Hold until every key item is taken and every sample has come back.
    task automatic drain();
        while (pending_keys.size() > 0 || key_bus.valid || expected_samples.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    // Mostly extremes and ramps of a few dozen ticks.
    function automatic t_reg pick_value(input bit is_step);
        case ($urandom_range(0, 5))
            0:       return is_step ? t_reg'(1) : t_reg'(0);
            1:       return FULL_SCALE;
            2:       return t_reg'($urandom_range(is_step, FULL_SCALE));
            default: return is_step ? t_reg'(FULL_SCALE / $urandom_range(1, 64))
                                    : t_reg'($urandom_range(0, FULL_SCALE));
        endcase
    endfunction

    // Whole notes with random timing, plus some raw noise.
    task automatic queue_random_notes(input int unsigned count);
        int unsigned queued;
        int unsigned hold_ticks;
        int unsigned ring_ticks;
        int unsigned i;
        queued = 0;
        while (queued < count) begin
            if ($urandom_range(0, 99) < 80) begin
                if ($urandom_range(0, 4) == 0)
                    add_keys(0, 1, 0, 1);
                else
                    add_keys(1, 0, 0, 1);
                hold_ticks = $urandom_range(0, 40);
                for (i = 0; i < hold_ticks; i++) begin
                    if ($urandom_range(0, 99) < 4)
                        pending_keys.push_back(t_keys'($urandom_range(0, 7)));
                    else
                        add_keys(0, 0, 0, 1);
                end
                add_keys(0, 0, 1, 1);
                ring_ticks = $urandom_range(0, 30);
                add_keys(0, 0, 0, ring_ticks);
                queued += 2 + hold_ticks + ring_ticks;
            end else begin
                hold_ticks = $urandom_range(1, 6);
                for (i = 0; i < hold_ticks; i++)
                    pending_keys.push_back(t_keys'($urandom_range(0, 7)));
                queued += hold_ticks;
            end
        end
    endtask

    initial begin
        t_reg init_lvl;
        t_reg atk_lvl;
        int unsigned phase;

        i_clk                 = 1'b0;
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        key_bus.valid         = 1'b0;
        key_bus.key_on        = 1'b0;
        key_bus.key_retrigger = 1'b0;
        key_bus.key_off       = 1'b0;
        env_bus.ready         = 1'b0;
        steady                = 1'b0;
        mismatch_count        = 0;

        cfg.initial_level = RST_INITIAL_LEVEL;
        cfg.attack_level  = RST_ATTACK_LEVEL;
        cfg.attack_step   = RST_ATTACK_STEP;
        cfg.decay_step    = RST_DECAY_STEP;
        cfg.release_step  = RST_RELEASE_STEP;
        env_level         = 0;
        env_stage         = ST_DONE;
        release_armed     = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: idle in done, release from done, strike, off during attack,
        // then every key at once.
        add_keys(0, 0, 0, 1);
        add_keys(0, 0, 1, 1);
        add_keys(1, 0, 0, 1);
        add_keys(0, 0, 0, 1);
        add_keys(0, 0, 1, 1);
        add_keys(0, 0, 0, 1);
        add_keys(1, 1, 1, 1);
        drain();

        // Full-scale everything: attack and decay fall through straight to sustain,
        // release lands exactly on zero.
        write_all(FULL_SCALE, FULL_SCALE, FULL_SCALE, FULL_SCALE, FULL_SCALE);
        add_keys(1, 0, 0, 1);
        add_keys(0, 0, 0, 1);
        add_keys(0, 0, 1, 1);
        drain();

        // Start at zero, overshoot on retrigger, release goes below zero.
        write_all(25'h0, FULL_SCALE, FULL_SCALE, 25'h300000, 25'h700000);
        add_keys(1, 0, 0, 1);
        add_keys(0, 0, 0, 3);
        add_keys(0, 1, 0, 1);
        add_keys(0, 0, 1, 1);
        add_keys(0, 0, 0, 3);
        drain();

        // Downward attack with undershoot; key_off while attacking stays pending.
        write_all(FULL_SCALE, 25'h0, 25'h500000, 25'h1, 25'h1);
        add_keys(1, 0, 0, 1);
        add_keys(0, 0, 0, 3);
        add_keys(0, 1, 1, 1);
        add_keys(0, 0, 0, 2);
        drain();

        // Random settings per phase; each phase starts from an idle block.
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            init_lvl = pick_value(1'b0);
            atk_lvl  = ($urandom_range(0, 4) == 0) ? init_lvl : pick_value(1'b0);
            write_all(init_lvl, atk_lvl, pick_value(1'b1), pick_value(1'b1),
                      pick_value(1'b1));
            steady = (phase == 4);
            queue_random_notes(PHASE_ITEMS);
            drain();
        end

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
